// ===== src/tlum_pkg.sv =====
// Shared widths and types for the tank level and usage monitor.
// Used by tlum_div and tank_level_usage_monitor_core; depends on nothing.
`default_nettype none

package tlum_pkg;

  localparam int SampleBits = 12;
  localparam int LevelW     = 7;
  localparam int UsageW     = 16;
  localparam int DaysW      = 8;
  localparam int PctScale   = 100;

  // (sample - empty) spans SampleBits+1 bits, times 100 adds LevelW bits
  localparam int NumW    = SampleBits + 1 + LevelW;
  localparam int DivCntW = $clog2(NumW + 1);

  // APB register map, byte address 4*index
  localparam int CfgAddrW = 5;
  localparam logic [2:0] RegRiseThr  = 3'd0;
  localparam logic [2:0] RegFullGate = 3'd1;
  localparam logic [2:0] RegNomFull  = 3'd2;
  localparam logic [2:0] RegNomEmpty = 3'd3;
  localparam logic [2:0] RegChkInt   = 3'd4;
  localparam logic [2:0] RegDayLen   = 3'd5;

  typedef struct packed {
    logic               start;
    logic [DivCntW-1:0] iters;
  } div_cmd_t;

endpackage

`default_nettype wire

// ===== src/tlum_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Uses tlum_pkg for widths and the command struct.
`default_nettype none

module tlum_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire tlum_pkg::div_cmd_t           cmd_i,
  input  wire logic [tlum_pkg::NumW-1:0]    dividend_i,
  input  wire logic [tlum_pkg::UsageW-1:0]  divisor_i,
  output logic                              busy_o,
  output logic [tlum_pkg::NumW-1:0]         quotient_o
);

  logic [tlum_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [tlum_pkg::NumW-1:0]    work_q;
  logic [tlum_pkg::UsageW-1:0]  rem_q, dvsr_q;
  logic [tlum_pkg::UsageW:0]    shifted;
  logic                         ge;
  logic [tlum_pkg::UsageW-1:0]  rem_next;

  // remainder stays below the divisor, so the shifted value fits UsageW+1 bits
  always_comb begin
    shifted  = {rem_q, work_q[tlum_pkg::NumW-1]};
    ge       = shifted >= {1'b0, dvsr_q};
    rem_next = ge ? tlum_pkg::UsageW'(shifted - {1'b0, dvsr_q})
                  : shifted[tlum_pkg::UsageW-1:0];
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.start) begin
      cnt_d = cmd_i.iters;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      work_q <= dividend_i;
      rem_q  <= '0;
      dvsr_q <= divisor_i;
    end else if (cnt_q != '0) begin
      work_q <= {work_q[tlum_pkg::NumW-2:0], ge};
      rem_q  <= rem_next;
    end
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = work_q;

endmodule

`default_nettype wire

// ===== src/tank_level_usage_monitor_core.sv =====
// Tank level and usage monitor: microcoded sequencer, APB registers, stream ports.
// Depends on tlum_pkg and tlum_div.
//
// Takes one sender sample with its millisecond timestamp per input beat and
// returns one result beat: level in percent, percent used today, days left and
// the calibration flags. One item is worked at a time by a ten-step microcode
// program over a shared bit-serial divider, and either of its two divisions
// (level, days left) can be skipped. The next sample can be taken in the
// cycle after the result is loaded. A finished result waits in the output
// register while the next sample is taken. Write registers only while the
// block is idle.
`default_nettype none

module tank_level_usage_monitor_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // sample_code [11:0], time_ms [43:12]
  input  wire logic [47:0]                    s_axis_tdata_i,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // level_percent [6:0], usage_today [22:7], days_left [30:23],
  // is_calibrated [31], fill_detected [32]
  output logic [39:0]                         m_axis_tdata_o,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [tlum_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int SW = tlum_pkg::SampleBits;
  localparam int LW = tlum_pkg::LevelW;
  localparam int UW = tlum_pkg::UsageW;
  localparam int NW = tlum_pkg::NumW;

  // datapath operations
  localparam logic [3:0] OpNop      = 4'd0;
  localparam logic [3:0] OpWait     = 4'd1;
  localparam logic [3:0] OpCheck    = 4'd2;
  localparam logic [3:0] OpPrepLvl  = 4'd3;
  localparam logic [3:0] OpDiv      = 4'd4;
  localparam logic [3:0] OpLevel    = 4'd5;
  localparam logic [3:0] OpDay      = 4'd6;
  localparam logic [3:0] OpPrepDays = 4'd7;
  localparam logic [3:0] OpDays     = 4'd8;
  localparam logic [3:0] OpEmit     = 4'd9;

  // sequencing
  localparam logic [1:0] CondSeq      = 2'd0;
  localparam logic [1:0] CondHold     = 2'd1;
  localparam logic [1:0] CondBranch   = 2'd2;
  localparam logic [1:0] CondHoldGoto = 2'd3;

  localparam logic signed [SW+1:0] EmptyHi = {2'b00, {SW{1'b1}}};
  localparam logic signed [SW+1:0] EmptyLo = {2'b11, {SW{1'b0}}};

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] cond;
    logic [3:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [3:0] addr);
    ucode_t w;
    unique case (addr)
      4'd0:    w = '{op: OpWait,     cond: CondHold,     target: 4'd0};
      4'd1:    w = '{op: OpCheck,    cond: CondSeq,      target: 4'd0};
      4'd2:    w = '{op: OpPrepLvl,  cond: CondBranch,   target: 4'd4};
      4'd3:    w = '{op: OpDiv,      cond: CondHold,     target: 4'd0};
      4'd4:    w = '{op: OpLevel,    cond: CondSeq,      target: 4'd0};
      4'd5:    w = '{op: OpDay,      cond: CondSeq,      target: 4'd0};
      4'd6:    w = '{op: OpPrepDays, cond: CondBranch,   target: 4'd8};
      4'd7:    w = '{op: OpDiv,      cond: CondHold,     target: 4'd0};
      4'd8:    w = '{op: OpDays,     cond: CondSeq,      target: 4'd0};
      4'd9:    w = '{op: OpEmit,     cond: CondHoldGoto, target: 4'd0};
      default: w = '{op: OpNop,      cond: CondHoldGoto, target: 4'd0};
    endcase
    return w;
  endfunction

  // configuration
  logic [SW-1:0] rise_thr_q, full_gate_q, nom_full_q, nom_empty_q;
  logic [15:0]   chk_int_q;
  logic [31:0]   day_len_q;

  // persistent state
  logic [SW-1:0]      prev_chk_sample_q;
  logic [31:0]        prev_chk_time_q;
  logic               cal_valid_q;
  logic signed [SW:0] cal_empty_q;
  logic [LW-1:0]      prev_level_q;
  logic               prev_level_valid_q;
  logic [31:0]        day_start_q;
  logic [UW-1:0]      daily_used_q;

  // per-item working registers
  logic [SW-1:0] sample_q;
  logic [31:0]   time_q;
  logic          fill_q;
  logic          lvl_skip_q, days_skip_q;
  logic [LW-1:0] level_q;
  logic [7:0]    days_q;

  logic [3:0]  step_q, step_d;
  logic        out_valid_q;
  logic [39:0] out_data_q;

  ucode_t uw;
  logic   flag;
  logic   in_beat, out_block, cfg_wr;

  // datapath combinational
  logic [31:0]          chk_elapsed, day_elapsed;
  logic                 chk_due, rise_ok, gate_ok, day_over;
  logic [SW:0]          rise_lim;
  logic signed [SW+1:0] cal_raw;
  logic signed [SW:0]   cal_sat, empty_code, span;
  logic signed [SW+1:0] diff;
  logic                 lvl_skip, days_skip;
  logic [NW-1:0]        num;
  logic [LW-1:0]        lvl_calc, drop;
  logic [UW:0]          used_sum;

  tlum_pkg::div_cmd_t  div_cmd;
  logic [NW-1:0]       div_dividend, div_quot;
  logic [UW-1:0]       div_divisor;
  logic                div_busy;

  assign uw = ucode_rom(step_q);

  always_comb begin
    chk_elapsed = time_q - prev_chk_time_q;
    chk_due     = chk_elapsed > {16'd0, chk_int_q};
    rise_lim    = {1'b0, prev_chk_sample_q} + {1'b0, rise_thr_q};
    rise_ok     = {1'b0, sample_q} > rise_lim;
    gate_ok     = sample_q > full_gate_q;
    cal_raw     = $signed({2'b00, nom_empty_q}) + $signed({2'b00, sample_q})
                - $signed({2'b00, nom_full_q});
    if (cal_raw > EmptyHi) begin
      cal_sat = EmptyHi[SW:0];
    end else if (cal_raw < EmptyLo) begin
      cal_sat = EmptyLo[SW:0];
    end else begin
      cal_sat = cal_raw[SW:0];
    end

    empty_code = cal_valid_q ? cal_empty_q : $signed({1'b0, nom_empty_q});
    span       = $signed({1'b0, nom_full_q}) - $signed({1'b0, nom_empty_q});
    diff       = $signed({2'b00, sample_q}) - $signed({empty_code[SW], empty_code});
    lvl_skip   = span[SW] || (span == '0) || diff[SW+1] || (diff == '0);
    num        = NW'(diff[SW:0]) * NW'(tlum_pkg::PctScale);

    // clamp the level quotient to full; a skipped level division gives zero
    if (lvl_skip_q) begin
      lvl_calc = '0;
    end else if (div_quot > NW'(tlum_pkg::PctScale)) begin
      lvl_calc = LW'(tlum_pkg::PctScale);
    end else begin
      lvl_calc = div_quot[LW-1:0];
    end
    drop     = prev_level_q - lvl_calc;
    used_sum = {1'b0, daily_used_q} + (UW+1)'(drop);

    day_elapsed = time_q - day_start_q;
    day_over    = day_elapsed > day_len_q;
    days_skip   = daily_used_q == '0;
  end

  // divider command
  always_comb begin
    div_cmd      = '{start: 1'b0, iters: '0};
    div_dividend = num;
    div_divisor  = UW'(span[SW-1:0]);
    if (uw.op == OpPrepLvl) begin
      div_cmd = '{start: !lvl_skip, iters: tlum_pkg::DivCntW'(NW)};
    end else if (uw.op == OpPrepDays) begin
      div_cmd      = '{start: !days_skip, iters: tlum_pkg::DivCntW'(LW)};
      div_dividend = {prev_level_q, {(NW-LW){1'b0}}};
      div_divisor  = daily_used_q;
    end
  end

  tlum_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (div_cmd),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  assign s_axis_tready_o = uw.op == OpWait;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_block       = out_valid_q && !m_axis_tready_i;

  always_comb begin
    unique case (uw.op)
      OpWait:     flag = !s_axis_tvalid_i;
      OpPrepLvl:  flag = lvl_skip;
      OpDiv:      flag = div_busy;
      OpPrepDays: flag = days_skip;
      OpEmit:     flag = out_block;
      default:    flag = 1'b0;
    endcase
  end

  always_comb begin
    unique case (uw.cond)
      CondSeq:      step_d = step_q + 1'b1;
      CondHold:     step_d = flag ? step_q : step_q + 1'b1;
      CondBranch:   step_d = flag ? uw.target : step_q + 1'b1;
      CondHoldGoto: step_d = flag ? step_q : uw.target;
      default:      step_d = 4'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q             <= 4'd0;
      out_valid_q        <= 1'b0;
      prev_chk_sample_q  <= '0;
      prev_chk_time_q    <= '0;
      cal_valid_q        <= 1'b0;
      cal_empty_q        <= '0;
      prev_level_q       <= '0;
      prev_level_valid_q <= 1'b0;
      day_start_q        <= '0;
      daily_used_q       <= '0;
    end else begin
      step_q <= step_d;

      if (uw.op == OpEmit && !out_block) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      if (uw.op == OpCheck && chk_due) begin
        if (rise_ok && gate_ok) begin
          cal_empty_q <= cal_sat;
          cal_valid_q <= 1'b1;
        end
        prev_chk_sample_q <= sample_q;
        prev_chk_time_q   <= time_q;
      end

      // add the drop first; the day clear follows in the next step
      if (uw.op == OpLevel && prev_level_valid_q && (lvl_calc < prev_level_q)) begin
        daily_used_q <= used_sum[UW] ? {UW{1'b1}} : used_sum[UW-1:0];
      end

      if (uw.op == OpDay) begin
        prev_level_q <= level_q;
        if (!prev_level_valid_q) begin
          prev_level_valid_q <= 1'b1;
          day_start_q        <= time_q;
        end else if (day_over) begin
          daily_used_q <= '0;
          day_start_q  <= time_q;
        end
      end
    end
  end

  // prev_level_q holds this item's level from the day step on
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      sample_q <= s_axis_tdata_i[SW-1:0];
      time_q   <= s_axis_tdata_i[SW+31:SW];
    end
    if (uw.op == OpCheck) begin
      fill_q <= chk_due && rise_ok && gate_ok;
    end
    if (uw.op == OpPrepLvl) begin
      lvl_skip_q <= lvl_skip;
    end
    if (uw.op == OpLevel) begin
      level_q <= lvl_calc;
    end
    if (uw.op == OpPrepDays) begin
      days_skip_q <= days_skip;
    end
    if (uw.op == OpDays) begin
      days_q <= days_skip_q ? 8'hFF : 8'(div_quot[LW-1:0]);
    end
    if (uw.op == OpEmit && !out_block) begin
      out_data_q <= {7'd0, fill_q, cal_valid_q, days_q, daily_used_q, level_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_thr_q  <= SW'(372);
      full_gate_q <= SW'(3102);
      nom_full_q  <= SW'(3599);
      nom_empty_q <= SW'(2048);
      chk_int_q   <= 16'd5000;
      day_len_q   <= 32'd86400000;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        tlum_pkg::RegRiseThr:  rise_thr_q  <= pwdata[SW-1:0];
        tlum_pkg::RegFullGate: full_gate_q <= pwdata[SW-1:0];
        tlum_pkg::RegNomFull:  nom_full_q  <= pwdata[SW-1:0];
        tlum_pkg::RegNomEmpty: nom_empty_q <= pwdata[SW-1:0];
        tlum_pkg::RegChkInt:   chk_int_q   <= pwdata[15:0];
        tlum_pkg::RegDayLen:   day_len_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      tlum_pkg::RegRiseThr:  prdata = 32'(rise_thr_q);
      tlum_pkg::RegFullGate: prdata = 32'(full_gate_q);
      tlum_pkg::RegNomFull:  prdata = 32'(nom_full_q);
      tlum_pkg::RegNomEmpty: prdata = 32'(nom_empty_q);
      tlum_pkg::RegChkInt:   prdata = 32'(chk_int_q);
      tlum_pkg::RegDayLen:   prdata = day_len_q;
      default:               prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire
